>>> hdl/mte_pkg.sv
package mte_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned WORD_W = 24;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned GRP_W = 3;
  localparam int unsigned STEP_W = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  // status high nibbles
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON = 4'h9;
  localparam logic [3:0] NIB_POLY_AT = 4'ha;
  localparam logic [3:0] NIB_CTRL = 4'hb;
  localparam logic [3:0] NIB_PROGRAM = 4'hc;
  localparam logic [3:0] NIB_CHAN_PRES = 4'hd;
  localparam logic [3:0] NIB_BEND = 4'he;

  typedef enum logic [1:0] {
    KIND_THREE,
    KIND_TWO,
    KIND_BAD
  } kind_e;

  typedef struct packed {
    logic [TIME_W-1:0] delta;
    logic [GRP_W-1:0]  ngrp;
    kind_e             kind;
    logic [BYTE_W-1:0] status;
    logic [BYTE_W-1:0] d1;
    logic [BYTE_W-1:0] d2;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> hdl/mte_if.sv
interface mte_evt_if;
  import mte_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] event_time;
  logic [WORD_W-1:0] event_word;

  modport source (output valid, output event_time, output event_word, input ready);
  modport sink (input valid, input event_time, input event_word, output ready);
endinterface

interface mte_res_if;
  import mte_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               is_last;
  logic               bad_status;
  logic [TOTAL_W-1:0] bytes_so_far;

  modport source (output valid, output out_byte, output is_last, output bad_status,
                  output bytes_so_far, input ready);
  modport sink (input valid, input out_byte, input is_last, input bad_status,
                input bytes_so_far, output ready);
endinterface

>>> hdl/midi_event_to_smf_track_bytes.sv
// Encodes timestamped MIDI channel events into Standard MIDI File track bytes.
// Each accepted request (absolute time plus packed event word) produces the delta
// time since the previous request as a big-endian variable-length quantity (one to
// five bytes, continuation bit on all but the last), then the status byte and one
// or two data bytes. A low byte with bit 7 clear reuses the last status seen
// (running status); in that case byte0 and byte1 are the data bytes. Unsupported
// or missing status yields the delta bytes followed by one error result: byte 0,
// is_last and bad_status set, not counted in bytes_so_far. Every result carries
// the running byte count. Throughput: one result per clock while the sink is ready,
// set by the single output byte lane of the back end; a request yields 2 to 8
// results (delta bytes plus event bytes). The front end resolves status and delta
// in the accept cycle and parks the request in a QueueDepth-entry queue, so new
// requests keep being taken, until the queue is full, while earlier ones are still
// being serialized. A first result passes the queue entry, then the output register.
module midi_event_to_smf_track_bytes #(
  parameter int unsigned QueueDepth = mte_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mte_evt_if.sink    in_i,
  mte_res_if.source  out_o
);
  import mte_pkg::*;

  // front to back handoff
  logic    push;
  logic    pop;
  cmd_t    cmd;
  cmd_t    head;
  q_stat_t q_stat;

  // status resolution, delta and group count, classification
  mte_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .evt_i    (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .cmd_o    (cmd)
  );

  // decoupling queue between classification and serialization
  mte_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  // byte serializer with registered output and running total
  mte_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .res_o    (out_o)
  );

  // the serializer never retires a queue entry that is not there
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  // an error result is always the closing, zero-valued result of its request
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.bad_status) |-> (out_o.is_last && out_o.out_byte == '0))
    else $error("error result not final or nonzero");

  // a request into an idle block shows its first result through the queue entry and the output register
  a_idle_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && q_stat.empty && !out_o.valid) |-> ##2 out_o.valid)
    else $error("first result late");

endmodule

>>> hdl/mte_front.sv
module mte_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  mte_evt_if.sink           evt_i,
  input  mte_pkg::q_stat_t  q_stat_i,
  output logic              push_o,
  output mte_pkg::cmd_t     cmd_o
);
  import mte_pkg::*;

  logic [TIME_W-1:0] prev_q, prev_d;
  logic [BYTE_W-1:0] rs_q, rs_d;
  logic [BYTE_W-1:0] b0, b1, b2;
  logic [TIME_W-1:0] delta;
  logic [BYTE_W-1:0] status;
  logic              accept;

  assign evt_i.ready = !q_stat_i.full;
  assign accept      = evt_i.valid && !q_stat_i.full;
  assign push_o      = accept;

  assign b0 = evt_i.event_word[7:0];
  assign b1 = evt_i.event_word[15:8];
  assign b2 = evt_i.event_word[23:16];

  assign status = b0[7] ? b0 : rs_q;
  assign delta  = evt_i.event_time - prev_q;

  always_comb begin
    cmd_o.delta  = delta;
    cmd_o.status = status;
    cmd_o.d1     = b0[7] ? b1 : b0;
    cmd_o.d2     = b0[7] ? b2 : b1;

    // number of seven-bit groups, capped at five
    if (delta[31:28] != '0) begin
      cmd_o.ngrp = GRP_W'(5);
    end else if (delta[27:21] != '0) begin
      cmd_o.ngrp = GRP_W'(4);
    end else if (delta[20:14] != '0) begin
      cmd_o.ngrp = GRP_W'(3);
    end else if (delta[13:7] != '0) begin
      cmd_o.ngrp = GRP_W'(2);
    end else begin
      cmd_o.ngrp = GRP_W'(1);
    end

    case (status[7:4])
      NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_BEND: cmd_o.kind = KIND_THREE;
      NIB_PROGRAM, NIB_CHAN_PRES: cmd_o.kind = KIND_TWO;
      default: cmd_o.kind = KIND_BAD;
    endcase
  end

  assign prev_d = accept ? evt_i.event_time : prev_q;
  assign rs_d   = (accept && b0[7]) ? b0 : rs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      rs_q   <= '0;
    end else begin
      prev_q <= prev_d;
      rs_q   <= rs_d;
    end
  end

endmodule

>>> hdl/mte_queue.sv
module mte_queue #(
  parameter int unsigned Depth = mte_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mte_pkg::cmd_t     cmd_i,
  input  logic              pop_i,
  output mte_pkg::cmd_t     head_o,
  output mte_pkg::q_stat_t  stat_o
);
  import mte_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cmd_t             mem_q [Depth];
  logic [AddrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  function automatic logic [AddrW-1:0] next_ptr(input logic [AddrW-1:0] p);
    logic [AddrW-1:0] r;
    if (p == AddrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + AddrW'(1);
    end
    return r;
  endfunction

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_q];

  assign wr_d = push_i ? next_ptr(wr_q) : wr_q;
  assign rd_d = pop_i ? next_ptr(rd_q) : rd_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> hdl/mte_back.sv
module mte_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mte_pkg::cmd_t     head_i,
  input  mte_pkg::q_stat_t  q_stat_i,
  output logic              pop_o,
  mte_res_if.source         res_o
);
  import mte_pkg::*;

  logic [STEP_W-1:0]  step_q, step_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               vld_q, vld_d;
  logic [BYTE_W-1:0]  byte_q;
  logic               last_q, bad_q;
  logic [TOTAL_W-1:0] sofar_q;

  logic              out_free, emit;
  logic              in_vlq;
  logic [GRP_W-1:0]  grp_idx;
  logic [STEP_W-1:0] ev_idx;
  logic [BYTE_W-1:0] cur_byte;
  logic              cur_last, cur_bad;

  assign out_free = !vld_q || res_o.ready;
  assign emit     = !q_stat_i.empty && out_free;
  assign pop_o    = emit && cur_last;

  assign in_vlq  = (step_q < head_i.ngrp);
  assign grp_idx = head_i.ngrp - GRP_W'(1) - step_q;
  assign ev_idx  = step_q - head_i.ngrp;

  always_comb begin
    cur_byte = '0;
    cur_last = 1'b0;
    cur_bad  = 1'b0;
    if (in_vlq) begin
      // big-endian groups, continuation bit on all but the lowest
      case (grp_idx)
        3'd0: cur_byte = {1'b0, head_i.delta[6:0]};
        3'd1: cur_byte = {1'b1, head_i.delta[13:7]};
        3'd2: cur_byte = {1'b1, head_i.delta[20:14]};
        3'd3: cur_byte = {1'b1, head_i.delta[27:21]};
        3'd4: cur_byte = {1'b1, 3'b000, head_i.delta[31:28]};
        default: cur_byte = '0;
      endcase
    end else begin
      case (head_i.kind)
        KIND_THREE: begin
          cur_last = (ev_idx == STEP_W'(2));
          case (ev_idx)
            3'd0: cur_byte = head_i.status;
            3'd1: cur_byte = head_i.d1;
            default: cur_byte = head_i.d2;
          endcase
        end
        KIND_TWO: begin
          cur_last = (ev_idx == STEP_W'(1));
          cur_byte = (ev_idx == '0) ? head_i.status : head_i.d1;
        end
        default: begin
          cur_last = 1'b1;
          cur_bad  = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    step_d  = step_q;
    total_d = total_q;
    vld_d   = vld_q;
    if (emit) begin
      step_d  = cur_last ? '0 : step_q + STEP_W'(1);
      total_d = cur_bad ? total_q : total_q + TOTAL_W'(1);
      vld_d   = 1'b1;
    end else if (res_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      total_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      step_q  <= step_d;
      total_q <= total_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q  <= cur_byte;
      last_q  <= cur_last;
      bad_q   <= cur_bad;
      sofar_q <= total_d;
    end
  end

  assign res_o.valid        = vld_q;
  assign res_o.out_byte     = byte_q;
  assign res_o.is_last      = last_q;
  assign res_o.bad_status   = bad_q;
  assign res_o.bytes_so_far = sofar_q;

endmodule
